// ===== src/owr_pkg.sv =====
// Shared constants, codes and types of the oldest-replacement watch table.
package owr_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 8;
   localparam int SIGNAL_COUNT          = 1024;

   localparam int SIG_W    = 10;
   localparam int STAMP_W  = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 3;
   localparam int CMP_W    = 17;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_ADDED_FREE    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ADDED_REPLACE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT       = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED       = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_PRESENT   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED       = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic clr_one;
      logic clr_all;
   } store_cmd_type;

endpackage

// ===== src/owr_store.sv =====
// Entry storage: signal and stamp memories with flip-flop valid bits.
module owr_store #(
   parameter int TABLE_ENTRIES = owr_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic                        rd_valid,
   output logic [owr_pkg::SIG_W-1:0]   rd_sig,
   output logic [owr_pkg::STAMP_W-1:0] rd_stamp,
   input  owr_pkg::store_cmd_type      cmd,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [owr_pkg::SIG_W-1:0]   wr_sig,
   input  logic [owr_pkg::STAMP_W-1:0] wr_stamp
);

   logic [owr_pkg::SIG_W-1:0]   sig_mem_ff   [TABLE_ENTRIES];
   logic [owr_pkg::STAMP_W-1:0] stamp_mem_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]    valid_ff;
   logic [TABLE_ENTRIES-1:0]    valid_in;
   logic                        rd_valid_ff;
   logic [owr_pkg::SIG_W-1:0]   rd_sig_ff;
   logic [owr_pkg::STAMP_W-1:0] rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         sig_mem_ff[wr_addr]   <= wr_sig;
         stamp_mem_ff[wr_addr] <= wr_stamp;
      end
      rd_sig_ff   <= sig_mem_ff[rd_addr];
      rd_stamp_ff <= stamp_mem_ff[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clr_all) begin
         valid_in = '0;
      end else if (cmd.clr_one) begin
         valid_in[wr_addr] = 1'b0;
      end else if (cmd.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_sig   = rd_sig_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule

// ===== src/owr_ctrl.sv =====
// Command sequencer: entry scan with a shared compare unit, decision and result register.
module owr_ctrl #(
   parameter int TABLE_ENTRIES = owr_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [owr_pkg::MODE_W-1:0]   req_mode,
   input  logic [owr_pkg::SIG_W-1:0]    req_signal_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [owr_pkg::STATUS_W-1:0] rsp_status,
   output logic [owr_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                         rsp_evicted_valid,
   output logic [owr_pkg::SIG_W-1:0]    rsp_evicted_signal,
   output logic [IDX_W-1:0]             rd_addr,
   input  logic                         rd_valid,
   input  logic [owr_pkg::SIG_W-1:0]    rd_sig,
   input  logic [owr_pkg::STAMP_W-1:0]  rd_stamp,
   output owr_pkg::store_cmd_type       cmd,
   output logic [IDX_W-1:0]             wr_addr,
   output logic [owr_pkg::SIG_W-1:0]    wr_sig,
   output logic [owr_pkg::STAMP_W-1:0]  wr_stamp
);

   localparam int                SLOT_EXT_W = IDX_W + owr_pkg::SLOT_W;
   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);

   owr_pkg::state_type state_ff, state_in;

   logic [owr_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [owr_pkg::SIG_W-1:0]    sig_ff, sig_in;
   logic                         bad_ff, bad_in;
   logic [IDX_W-1:0]             cnt_ff, cnt_in;
   logic                         issue_ff, issue_in;
   logic                         eval_ff, eval_in;
   logic [IDX_W-1:0]             eval_idx_ff, eval_idx_in;
   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             match_ff, match_in;
   logic                         have_free_ff, have_free_in;
   logic [IDX_W-1:0]             free_ff, free_in;
   logic                         have_old_ff, have_old_in;
   logic [IDX_W-1:0]             old_slot_ff, old_slot_in;
   logic [owr_pkg::STAMP_W-1:0]  old_stamp_ff, old_stamp_in;
   logic [owr_pkg::SIG_W-1:0]    old_sig_ff, old_sig_in;
   logic [owr_pkg::STAMP_W-1:0]  counter_ff, counter_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [owr_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [owr_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                         rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [owr_pkg::SIG_W-1:0]    rsp_ev_sig_ff, rsp_ev_sig_in;

   logic                         accept;
   logic                         out_free;
   logic                         fire;
   logic                         sig_match;
   logic                         stamp_older;
   logic [owr_pkg::STATUS_W-1:0] sel_status;
   logic [IDX_W-1:0]             sel_slot;
   logic                         sel_evict;
   logic                         sel_write;
   logic                         sel_clr_one;
   logic                         sel_clr_all;
   logic [SLOT_EXT_W-1:0]        slot_ext;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = (state_ff == owr_pkg::ST_FINISH) && out_free;

   assign sig_match   = rd_sig == sig_ff;
   assign stamp_older = rd_stamp < old_stamp_ff;

   // decide the command outcome from the scan results
   always_comb begin
      sel_status  = owr_pkg::STATUS_NOT_PRESENT;
      sel_slot    = '0;
      sel_evict   = 1'b0;
      sel_write   = 1'b0;
      sel_clr_one = 1'b0;
      sel_clr_all = 1'b0;
      if (mode_ff == owr_pkg::MODE_CLEAR) begin
         sel_status  = owr_pkg::STATUS_CLEARED;
         sel_clr_all = 1'b1;
      end else if (bad_ff) begin
         sel_status = owr_pkg::STATUS_NOT_PRESENT;
      end else if (mode_ff == owr_pkg::MODE_REMOVE) begin
         if (found_ff) begin
            sel_status  = owr_pkg::STATUS_REMOVED;
            sel_slot    = match_ff;
            sel_clr_one = 1'b1;
         end
      end else if (found_ff) begin
         sel_status = owr_pkg::STATUS_PRESENT;
         sel_slot   = match_ff;
      end else if (have_free_ff) begin
         sel_status = owr_pkg::STATUS_ADDED_FREE;
         sel_slot   = free_ff;
         sel_write  = 1'b1;
      end else begin
         sel_status = owr_pkg::STATUS_ADDED_REPLACE;
         sel_slot   = old_slot_ff;
         sel_evict  = 1'b1;
         sel_write  = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      sig_in       = sig_ff;
      bad_in       = bad_ff;
      cnt_in       = cnt_ff;
      issue_in     = issue_ff;
      eval_in      = 1'b0;
      eval_idx_in  = cnt_ff;
      found_in     = found_ff;
      match_in     = match_ff;
      have_free_in = have_free_ff;
      free_in      = free_ff;
      have_old_in  = have_old_ff;
      old_slot_in  = old_slot_ff;
      old_stamp_in = old_stamp_ff;
      old_sig_in   = old_sig_ff;
      counter_in   = counter_ff;
      case (state_ff)
         owr_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in      = req_mode;
               sig_in       = req_signal_index;
               bad_in       = (req_mode == owr_pkg::MODE_UNUSED) ||
                  ({{(owr_pkg::CMP_W - owr_pkg::SIG_W){1'b0}}, req_signal_index} >=
                   owr_pkg::CMP_W'(owr_pkg::SIGNAL_COUNT));
               cnt_in       = '0;
               issue_in     = 1'b1;
               found_in     = 1'b0;
               match_in     = '0;
               have_free_in = 1'b0;
               free_in      = '0;
               have_old_in  = 1'b0;
               old_slot_in  = '0;
               old_stamp_in = '0;
               old_sig_in   = '0;
               if (req_mode == owr_pkg::MODE_CLEAR || bad_in) begin
                  state_in = owr_pkg::ST_FINISH;
               end else begin
                  state_in = owr_pkg::ST_SCAN;
               end
            end
         end
         owr_pkg::ST_SCAN: begin
            if (issue_ff) begin
               eval_in = 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            if (eval_ff) begin
               if (rd_valid) begin
                  if (!found_ff && sig_match) begin
                     found_in = 1'b1;
                     match_in = eval_idx_ff;
                  end
                  if (!have_old_ff || stamp_older) begin
                     have_old_in  = 1'b1;
                     old_slot_in  = eval_idx_ff;
                     old_stamp_in = rd_stamp;
                     old_sig_in   = rd_sig;
                  end
               end else if (!have_free_ff) begin
                  have_free_in = 1'b1;
                  free_in      = eval_idx_ff;
               end
               if (!issue_ff) begin
                  state_in = owr_pkg::ST_FINISH;
               end
            end
         end
         owr_pkg::ST_FINISH: begin
            if (out_free) begin
               if (sel_write) begin
                  counter_in = counter_ff + 1'b1;
               end
               state_in = owr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = owr_pkg::ST_IDLE;
         end
      endcase
   end

   // result register: load on finish, drop on transfer
   always_comb begin
      slot_ext        = SLOT_EXT_W'(sel_slot);
      rsp_status_in   = rsp_status_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_sig_in   = rsp_ev_sig_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      if (fire) begin
         rsp_valid_in    = 1'b1;
         rsp_status_in   = sel_status;
         rsp_slot_in     = slot_ext[owr_pkg::SLOT_W-1:0];
         rsp_ev_valid_in = sel_evict;
         rsp_ev_sig_in   = sel_evict ? old_sig_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= owr_pkg::ST_IDLE;
         issue_ff     <= 1'b0;
         eval_ff      <= 1'b0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         eval_ff      <= eval_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff         <= mode_in;
      sig_ff          <= sig_in;
      bad_ff          <= bad_in;
      cnt_ff          <= cnt_in;
      eval_idx_ff     <= eval_idx_in;
      found_ff        <= found_in;
      match_ff        <= match_in;
      have_free_ff    <= have_free_in;
      free_ff         <= free_in;
      have_old_ff     <= have_old_in;
      old_slot_ff     <= old_slot_in;
      old_stamp_ff    <= old_stamp_in;
      old_sig_ff      <= old_sig_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_sig_ff   <= rsp_ev_sig_in;
   end

   assign req_stall          = state_ff != owr_pkg::ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_evicted_valid  = rsp_ev_valid_ff;
   assign rsp_evicted_signal = rsp_ev_sig_ff;

   assign rd_addr     = cnt_ff;
   assign cmd.wr_en   = fire && sel_write;
   assign cmd.clr_one = fire && sel_clr_one;
   assign cmd.clr_all = fire && sel_clr_all;
   assign wr_addr     = sel_slot;
   assign wr_sig      = sig_ff;
   assign wr_stamp    = counter_ff;

endmodule

// ===== src/oldest_replacement_watch_table.sv =====
// Add and remove scan the entries one at a time through the shared match/stamp compare
// unit, behind a registered read stage, then decide and write back in the finish state;
// clear and rejected commands skip the scan and go straight to the finish state.
// A new command is taken only once the previous one has left the finish state, which
// waits while the reply register is still held by rsp_stall.
// Reset: synchronous, clears all valid bits, the add counter and both handshakes.
module oldest_replacement_watch_table #(
   parameter int TABLE_ENTRIES = owr_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [owr_pkg::MODE_W-1:0]   req_mode,
   input  logic [owr_pkg::SIG_W-1:0]    req_signal_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [owr_pkg::STATUS_W-1:0] rsp_status,
   output logic [owr_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                         rsp_evicted_valid,
   output logic [owr_pkg::SIG_W-1:0]    rsp_evicted_signal
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [IDX_W-1:0]            rd_addr;
   logic                        rd_valid;
   logic [owr_pkg::SIG_W-1:0]   rd_sig;
   logic [owr_pkg::STAMP_W-1:0] rd_stamp;
   owr_pkg::store_cmd_type      cmd;
   logic [IDX_W-1:0]            wr_addr;
   logic [owr_pkg::SIG_W-1:0]   wr_sig;
   logic [owr_pkg::STAMP_W-1:0] wr_stamp;

   owr_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_signal_index   (req_signal_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_signal (rsp_evicted_signal),
      .rd_addr            (rd_addr),
      .rd_valid           (rd_valid),
      .rd_sig             (rd_sig),
      .rd_stamp           (rd_stamp),
      .cmd                (cmd),
      .wr_addr            (wr_addr),
      .wr_sig             (wr_sig),
      .wr_stamp           (wr_stamp)
   );

   owr_store #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_valid (rd_valid),
      .rd_sig   (rd_sig),
      .rd_stamp (rd_stamp),
      .cmd      (cmd),
      .wr_addr  (wr_addr),
      .wr_sig   (wr_sig),
      .wr_stamp (wr_stamp)
   );

endmodule

// ===== sim/owr_watch_checker.sv =====
`timescale 1ns / 100ps
// Checker for the watch table: predicts every reply from accepted commands and compares.
module owr_watch_checker
   import owr_pkg::*;
#(
   parameter int ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [SIG_W-1:0]    req_signal_index,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [SLOT_W-1:0]   rsp_slot,
   input  logic                rsp_evicted_valid,
   input  logic [SIG_W-1:0]    rsp_evicted_signal,
   output int                  fail_count,
   output int                  outstanding
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic                evicted_valid;
      logic [SIG_W-1:0]    evicted_signal;
   } watch_reply_type;

   logic [SIG_W-1:0]   watch_signal [ENTRIES];
   bit                 watch_valid  [ENTRIES];
   logic [STAMP_W-1:0] watch_stamp  [ENTRIES];
   logic [STAMP_W-1:0] add_count;

   watch_reply_type due_replies [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic flag_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic watch_reply_type apply_watch_command(input logic [MODE_W-1:0] mode,
                                                           input logic [SIG_W-1:0]  idx);
      watch_reply_type r;
      bit found, have_free, have_old;
      int match_slot, free_slot, old_slot;
      logic [STAMP_W-1:0] old_stamp;
      r = '0;
      r.status = STATUS_NOT_PRESENT;
      found = 1'b0;
      have_free = 1'b0;
      have_old = 1'b0;
      match_slot = 0;
      free_slot = 0;
      old_slot = 0;
      old_stamp = '0;
      if (mode == MODE_CLEAR) begin
         for (int i = 0; i < ENTRIES; i++) watch_valid[i] = 1'b0;
         r.status = STATUS_CLEARED;
         return r;
      end
      if ((mode != MODE_ADD && mode != MODE_REMOVE) || idx >= SIGNAL_COUNT) return r;
      for (int i = 0; i < ENTRIES; i++) begin
         if (watch_valid[i]) begin
            if (!found && watch_signal[i] == idx) begin
               found = 1'b1;
               match_slot = i;
            end
            if (!have_old || watch_stamp[i] < old_stamp) begin
               have_old = 1'b1;
               old_stamp = watch_stamp[i];
               old_slot = i;
            end
         end else if (!have_free) begin
            have_free = 1'b1;
            free_slot = i;
         end
      end
      if (mode == MODE_REMOVE) begin
         if (found) begin
            watch_valid[match_slot] = 1'b0;
            r.status = STATUS_REMOVED;
            r.slot = match_slot[SLOT_W-1:0];
         end
         return r;
      end
      if (found) begin
         r.status = STATUS_PRESENT;
         r.slot = match_slot[SLOT_W-1:0];
      end else if (have_free) begin
         watch_signal[free_slot] = idx;
         watch_valid[free_slot] = 1'b1;
         watch_stamp[free_slot] = add_count;
         add_count = add_count + 1'b1;
         r.status = STATUS_ADDED_FREE;
         r.slot = free_slot[SLOT_W-1:0];
      end else begin
         r.status = STATUS_ADDED_REPLACE;
         r.slot = old_slot[SLOT_W-1:0];
         r.evicted_valid = 1'b1;
         r.evicted_signal = watch_signal[old_slot];
         watch_signal[old_slot] = idx;
         watch_valid[old_slot] = 1'b1;
         watch_stamp[old_slot] = add_count;
         add_count = add_count + 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      watch_reply_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            watch_signal[i] = '0;
            watch_valid[i] = 1'b0;
            watch_stamp[i] = '0;
         end
         add_count = '0;
         due_replies.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_replies.size() == 0) begin
               flag_mismatch("reply transfer with no command outstanding");
            end else begin
               want = due_replies.pop_front();
               if (rsp_status != want.status)
                  flag_mismatch($sformatf("status got %0d want %0d",
                                          rsp_status, want.status));
               if (rsp_slot != want.slot)
                  flag_mismatch($sformatf("slot got %0d want %0d", rsp_slot, want.slot));
               if (rsp_evicted_valid != want.evicted_valid)
                  flag_mismatch($sformatf("evicted_valid got %0d want %0d",
                                          rsp_evicted_valid, want.evicted_valid));
               if (rsp_evicted_signal != want.evicted_signal)
                  flag_mismatch($sformatf("evicted_signal got %0d want %0d",
                                          rsp_evicted_signal, want.evicted_signal));
            end
         end
         if (req_valid && !req_stall)
            due_replies.push_back(apply_watch_command(req_mode, req_signal_index));
         outstanding <= due_replies.size();
      end
   end

endmodule

// ===== sim/oldest_replacement_watch_table_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the watch table: clock, reset, command and reply traffic, verdict.
module oldest_replacement_watch_table_tb;
   import owr_pkg::*;

   localparam int ENTRIES        = TABLE_ENTRIES_DEFAULT;
   localparam int RANDOM_ITEMS   = 850;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 2 * ENTRIES + 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode = MODE_ADD;
   logic [SIG_W-1:0]    req_signal_index = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                rsp_evicted_valid;
   logic [SIG_W-1:0]    rsp_evicted_signal;

   int fail_count;
   int outstanding;
   int stall_left = 0;
   int quiet_cycles = 0;
   bit rsp_burst = 1'b0;
   bit hold_request = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   oldest_replacement_watch_table #(.TABLE_ENTRIES(ENTRIES)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_signal_index   (req_signal_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_signal (rsp_evicted_signal)
   );

   owr_watch_checker #(.ENTRIES(ENTRIES)) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_signal_index   (req_signal_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_signal (rsp_evicted_signal),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   function automatic int draw_wait(input bit burst);
      return burst ? 0 : $urandom_range(0, 17);
   endfunction

   task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [SIG_W-1:0] idx,
                           input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_signal_index <= idx;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // reply side: stall a drawn number of cycles after each transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) stall_left = draw_wait(rsp_burst);
         if (hold_request) begin
            stall_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [SIG_W-1:0]  pool [16];
      logic [MODE_W-1:0] cmd_mode;
      logic [SIG_W-1:0]  cmd_idx;
      int sent, pool_size, span, pick;
      bit burst, hold_done, drain_done;
      sent = 0;
      hold_done = 1'b0;
      drain_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_cmd(MODE_CLEAR, 10'd1023, draw_wait(0));
      send_cmd(MODE_REMOVE, 10'd5, draw_wait(0));
      send_cmd(MODE_ADD, 10'd0, draw_wait(0));
      send_cmd(MODE_ADD, 10'd1023, draw_wait(0));
      for (int k = 1; k <= 6; k++) send_cmd(MODE_ADD, k[SIG_W-1:0], draw_wait(0));
      send_cmd(MODE_ADD, 10'd1023, draw_wait(0));
      send_cmd(MODE_ADD, 10'd700, draw_wait(0));
      send_cmd(MODE_ADD, 10'd0, draw_wait(0));
      send_cmd(MODE_REMOVE, 10'd3, draw_wait(0));
      send_cmd(MODE_ADD, 10'd999, draw_wait(0));
      send_cmd(MODE_UNUSED, 10'd1023, draw_wait(0));
      send_cmd(MODE_REMOVE, 10'd1023, draw_wait(0));
      send_cmd(MODE_CLEAR, 10'd0, draw_wait(0));
      send_cmd(MODE_ADD, 10'd512, draw_wait(0));
      send_cmd(MODE_ADD, 10'd341, draw_wait(0));
      send_cmd(MODE_ADD, 10'd682, draw_wait(0));
      send_cmd(MODE_REMOVE, 10'd512, draw_wait(0));
      send_cmd(MODE_ADD, 10'd341, draw_wait(0));

      while (sent < RANDOM_ITEMS) begin
         pool_size = $urandom_range(9, 16);
         for (int k = 0; k < pool_size; k++) pool[k] = SIG_W'($urandom_range(0, 1023));
         span = $urandom_range(30, 70);
         burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < span; n++) begin
            pick = $urandom_range(0, 99);
            cmd_idx = pool[$urandom_range(0, pool_size - 1)];
            if (pick < 58) begin
               cmd_mode = MODE_ADD;
            end else if (pick < 82) begin
               cmd_mode = MODE_REMOVE;
            end else if (pick < 86) begin
               cmd_mode = MODE_CLEAR;
               cmd_idx = SIG_W'($urandom_range(0, 1023));
            end else if (pick < 90) begin
               cmd_mode = MODE_UNUSED;
               cmd_idx = SIG_W'($urandom_range(0, 1023));
            end else begin
               cmd_mode = ($urandom_range(0, 1) == 0) ? MODE_ADD : MODE_REMOVE;
               cmd_idx = SIG_W'($urandom_range(0, 1023));
            end
            send_cmd(cmd_mode, cmd_idx, draw_wait(burst));
            sent++;
         end
         if (!hold_done && sent >= 300) begin
            // back up the block while the reply side is held off
            hold_request = 1'b1;
            for (int n = 0; n < 12; n++) begin
               send_cmd(MODE_ADD, pool[$urandom_range(0, pool_size - 1)], 0);
               sent++;
            end
            hold_done = 1'b1;
         end
         if (!drain_done && sent >= 550) begin
            drain_replies();
            drain_done = 1'b1;
         end
      end

      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/owr_pkg.sv
src/owr_store.sv
src/owr_ctrl.sv
src/oldest_replacement_watch_table.sv
sim/owr_watch_checker.sv
sim/oldest_replacement_watch_table_tb.sv
